// ----- rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion wrappers shared by the RTL of the draw engine.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assertion on an explicit clock and active-low reset.
`define ASSERT_CLKED(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Assertion on the house clock and reset names.
`define ASSERT_DFLT(lbl, prop, msg) `ASSERT_CLKED(lbl, clk_i, rst_ni, prop, msg)

`endif

// ----- rtl/pmrde_pkg.sv -----
// ----------------------------------------------------------------------------
// pmrde_pkg
// Screen geometry, framebuffer sizing and operation codes of the draw engine.
// ----------------------------------------------------------------------------
`default_nettype none

package pmrde_pkg;

  localparam int unsigned SCREEN_WIDTH  = 400;
  localparam int unsigned SCREEN_HEIGHT = 300;

  // One byte covers a cell two pixels wide and four pixels tall.
  localparam int unsigned CELL_W    = 2;
  localparam int unsigned CELL_H    = 4;
  localparam int unsigned CELL_COLS = (SCREEN_WIDTH + CELL_W - 1) / CELL_W;
  localparam int unsigned CELL_ROWS = (SCREEN_HEIGHT + CELL_H - 1) / CELL_H;
  localparam int unsigned FB_BYTES  = CELL_COLS * CELL_ROWS;

  localparam int unsigned FB_AW = (FB_BYTES > 1) ? $clog2(FB_BYTES) : 1;
  localparam int unsigned CC_W  = (CELL_COLS > 1) ? $clog2(CELL_COLS) : 1;
  localparam int unsigned CR_W  = (CELL_ROWS > 1) ? $clog2(CELL_ROWS) : 1;

  // Coordinate widths: input coordinates, clipped ends, and clip sums.
  localparam int unsigned COORD_W = 9;
  localparam int unsigned END_W   = 10;
  localparam int unsigned SUM_W   = 11;

  localparam logic [7:0] BYTE_WHITE = 8'hFF;
  localparam logic [7:0] BYTE_BLACK = 8'h00;

  typedef enum logic [1:0] {
    OP_PIXEL = 2'd0,
    OP_RECT  = 2'd1,
    OP_FILL  = 2'd2,
    OP_READ  = 2'd3
  } op_e;

endpackage

`default_nettype wire

// ----- rtl/pmrde_ram.sv -----
// ----------------------------------------------------------------------------
// pmrde_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module pmrde_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/packed_mono_rect_draw_engine.sv -----
// ----------------------------------------------------------------------------
// packed_mono_rect_draw_engine
// Pixel, rectangle, fill and byte-read engine over a packed 1-bit framebuffer.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake                      Payload
//   s_axis    in         s_axis_tvalid / s_axis_tready  tuser: operation
//                                                       tdata: drawing arguments
//   m_axis    out        m_axis_tvalid / m_axis_tready  tdata: read_data
//                                                       tuser: index_valid
//
// A rectangle or pixel passes CLIP, PLAN and BASE, walks each touched byte,
// then a drain and a response step. The byte walk is set by the RAM: one
// read and one write per cycle, overlapped as a two-stage read-modify-write.
// A fill writes all FB_BYTES bytes (15000 at 400x300), one per cycle; a read
// has a read and a data step. The block takes a new transfer only while its
// sequencer is idle; a finished result waits in the output register, so a
// stalled result stalls the next item only at its response.
// Reset clears the sequencer and the output valid; the framebuffer is not
// cleared and holds unknown bytes until a fill or drawing writes them.
//
`default_nettype none
`include "assert_macros.svh"

module packed_mono_rect_draw_engine
  import pmrde_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,

  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // [8:0] x_pos, [17:9] y_pos, [27:18] rect_width, [37:28] rect_height,
  // [38] color, [39] filled, [53:40] read_index, [55:54] zero
  input  wire logic [55:0] s_axis_tdata,
  // [1:0] operation
  input  wire logic [1:0]  s_axis_tuser,

  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // [7:0] read_data
  output logic      [7:0]  m_axis_tdata,
  // [0] index_valid
  output logic      [0:0]  m_axis_tuser
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLIP,
    ST_PLAN,
    ST_BASE,
    ST_WALK,
    ST_DRAIN,
    ST_FILL,
    ST_READ,
    ST_RDATA,
    ST_RESP
  } state_e;

  // Input fields.
  op_e                in_op;
  logic [COORD_W-1:0] in_x;
  logic [COORD_W-1:0] in_y;
  logic [END_W-1:0]   in_w;
  logic [END_W-1:0]   in_h;
  logic               in_color;
  logic               in_filled;
  logic [13:0]        in_ridx;
  logic               in_accept;

  assign in_op     = op_e'(s_axis_tuser);
  assign in_x      = s_axis_tdata[8:0];
  assign in_y      = s_axis_tdata[17:9];
  assign in_w      = s_axis_tdata[27:18];
  assign in_h      = s_axis_tdata[37:28];
  assign in_color  = s_axis_tdata[38];
  assign in_filled = s_axis_tdata[39];
  assign in_ridx   = s_axis_tdata[53:40];
  assign in_accept = s_axis_tvalid && s_axis_tready;

  // Sequencer and working registers.
  state_e             state_q, state_d;
  logic [COORD_W-1:0] x_q, x_d, y_q, y_d;
  logic [END_W-1:0]   w_q, w_d, h_q, h_d;
  logic               color_q, color_d, solid_q, solid_d;
  logic [13:0]        ridx_q, ridx_d;
  logic [END_W-1:0]   xe_q, xe_d, ye_q, ye_d;
  logic [COORD_W-1:0] xl_q, xl_d, fy_lo_q, fy_lo_d, fy_hi_q, fy_hi_d;
  logic [CC_W-1:0]    cx_q, cx_d, cx_last_q, cx_last_d;
  logic [CR_W-1:0]    cr_q, cr_d, cr_first_q, cr_first_d, cr_last_q, cr_last_d;
  logic [FB_AW-1:0]   prod_q, prod_d, addr_q, addr_d, col_base_q, col_base_d;

  // Write-back stage of the read-modify-write.
  logic               s1_valid_q, s1_valid_d;
  logic [FB_AW-1:0]   s1_addr_q, s1_addr_d;
  logic [7:0]         s1_mask_q, s1_mask_d;

  // Pending result and output register.
  logic [7:0]         res_data_q, res_data_d;
  logic               res_valid_q, res_valid_d;
  logic               m_tvalid_q, m_tvalid_d;
  logic [7:0]         m_tdata_q, m_tdata_d;
  logic               m_tuser_q, m_tuser_d;

  // RAM port signals.
  logic               ram_we, ram_re;
  logic [FB_AW-1:0]   ram_waddr, ram_raddr;
  logic [7:0]         ram_wdata, ram_rdata;

  // Clip arithmetic.
  logic [SUM_W-1:0]   xe_sum, ye_sum;
  logic               rect_empty;
  logic [COORD_W-1:0] plan_fy_lo, plan_fy_hi, plan_xl;

  // Bits of the current cell that the rectangle or its outline covers.
  logic [7:0]         cell_mask;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = m_tvalid_q;
  assign m_axis_tdata  = m_tdata_q;
  assign m_axis_tuser  = m_tuser_q;

  assign xe_sum = SUM_W'(x_q) + SUM_W'(w_q);
  assign ye_sum = SUM_W'(y_q) + SUM_W'(h_q);
  assign rect_empty = (w_q == '0) || (h_q == '0)
                   || (END_W'(x_q) >= END_W'(SCREEN_WIDTH))
                   || (END_W'(y_q) >= END_W'(SCREEN_HEIGHT));

  // Screen row y is stored at row SCREEN_HEIGHT-1-y, so the bottom screen
  // row of the rectangle becomes the lowest stored row.
  assign plan_xl    = COORD_W'(xe_q - END_W'(1));
  assign plan_fy_lo = COORD_W'(END_W'(SCREEN_HEIGHT) - ye_q);
  assign plan_fy_hi = COORD_W'(END_W'(SCREEN_HEIGHT - 1) - END_W'(y_q));

  always_comb begin
    logic [END_W-1:0] px;
    logic [END_W-1:0] fy;
    logic             in_rect;
    logic             on_border;
    cell_mask = '0;
    for (int r = 0; r < CELL_H; r++) begin
      for (int c = 0; c < CELL_W; c++) begin
        px = (END_W'(cx_q) << 1) | END_W'(c);
        fy = (END_W'(cr_q) << 2) | END_W'(r);
        in_rect = (px >= END_W'(x_q)) && (px <= END_W'(xl_q))
               && (fy >= END_W'(fy_lo_q)) && (fy <= END_W'(fy_hi_q));
        on_border = (px == END_W'(x_q)) || (px == END_W'(xl_q))
                 || (fy == END_W'(fy_lo_q)) || (fy == END_W'(fy_hi_q));
        cell_mask[7 - (r * CELL_W + c)] = in_rect && (solid_q || on_border);
      end
    end
  end

  // RAM ports: the fill sweep owns the write port in its state, otherwise the
  // write-back stage does. Reads serve the byte walk and the read operation.
  always_comb begin
    ram_we    = s1_valid_q || (state_q == ST_FILL);
    ram_waddr = (state_q == ST_FILL) ? addr_q : s1_addr_q;
    if (state_q == ST_FILL) begin
      ram_wdata = color_q ? BYTE_WHITE : BYTE_BLACK;
    end else if (color_q) begin
      ram_wdata = ram_rdata | s1_mask_q;
    end else begin
      ram_wdata = ram_rdata & ~s1_mask_q;
    end
    ram_re    = (state_q == ST_WALK) || (state_q == ST_READ);
    ram_raddr = (state_q == ST_READ) ? FB_AW'(ridx_q) : addr_q;
  end

  pmrde_ram #(
    .WIDTH (8),
    .DEPTH (FB_BYTES)
  ) u_frame_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    state_d     = state_q;
    x_d         = x_q;
    y_d         = y_q;
    w_d         = w_q;
    h_d         = h_q;
    color_d     = color_q;
    solid_d     = solid_q;
    ridx_d      = ridx_q;
    xe_d        = xe_q;
    ye_d        = ye_q;
    xl_d        = xl_q;
    fy_lo_d     = fy_lo_q;
    fy_hi_d     = fy_hi_q;
    cx_d        = cx_q;
    cx_last_d   = cx_last_q;
    cr_d        = cr_q;
    cr_first_d  = cr_first_q;
    cr_last_d   = cr_last_q;
    prod_d      = prod_q;
    addr_d      = addr_q;
    col_base_d  = col_base_q;
    s1_valid_d  = 1'b0;
    s1_addr_d   = s1_addr_q;
    s1_mask_d   = s1_mask_q;
    res_data_d  = res_data_q;
    res_valid_d = res_valid_q;
    m_tvalid_d  = m_tvalid_q && !m_axis_tready;
    m_tdata_d   = m_tdata_q;
    m_tuser_d   = m_tuser_q;

    case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          x_d         = in_x;
          y_d         = in_y;
          w_d         = in_w;
          h_d         = in_h;
          color_d     = in_color;
          solid_d     = in_filled;
          ridx_d      = in_ridx;
          addr_d      = '0;
          res_data_d  = '0;
          res_valid_d = 1'b1;
          case (in_op)
            OP_PIXEL: begin
              // A pixel is a filled one-by-one rectangle.
              w_d     = END_W'(1);
              h_d     = END_W'(1);
              solid_d = 1'b1;
              state_d = ST_CLIP;
            end
            OP_RECT: state_d = ST_CLIP;
            OP_FILL: state_d = ST_FILL;
            OP_READ: begin
              if (32'(in_ridx) < FB_BYTES) begin
                state_d = ST_READ;
              end else begin
                res_valid_d = 1'b0;
                state_d     = ST_RESP;
              end
            end
            default: state_d = ST_RESP;
          endcase
        end
      end

      ST_CLIP: begin
        xe_d = (xe_sum > SUM_W'(SCREEN_WIDTH)) ? END_W'(SCREEN_WIDTH) : END_W'(xe_sum);
        ye_d = (ye_sum > SUM_W'(SCREEN_HEIGHT)) ? END_W'(SCREEN_HEIGHT) : END_W'(ye_sum);
        state_d = rect_empty ? ST_RESP : ST_PLAN;
      end

      ST_PLAN: begin
        xl_d       = plan_xl;
        fy_lo_d    = plan_fy_lo;
        fy_hi_d    = plan_fy_hi;
        cx_d       = CC_W'(x_q >> 1);
        cx_last_d  = CC_W'(plan_xl >> 1);
        cr_d       = CR_W'(plan_fy_lo >> 2);
        cr_first_d = CR_W'(plan_fy_lo >> 2);
        cr_last_d  = CR_W'(plan_fy_hi >> 2);
        prod_d     = FB_AW'(FB_AW'(x_q >> 1) * FB_AW'(CELL_ROWS));
        state_d    = ST_BASE;
      end

      ST_BASE: begin
        addr_d     = prod_q + FB_AW'(cr_q);
        col_base_d = prod_q + FB_AW'(cr_q);
        state_d    = ST_WALK;
      end

      ST_WALK: begin
        // Read this cell now; its merge and write happen next cycle.
        s1_valid_d = 1'b1;
        s1_addr_d  = addr_q;
        s1_mask_d  = cell_mask;
        if (cr_q == cr_last_q) begin
          if (cx_q == cx_last_q) begin
            state_d = ST_DRAIN;
          end else begin
            cx_d       = cx_q + CC_W'(1);
            cr_d       = cr_first_q;
            col_base_d = col_base_q + FB_AW'(CELL_ROWS);
            addr_d     = col_base_q + FB_AW'(CELL_ROWS);
          end
        end else begin
          cr_d   = cr_q + CR_W'(1);
          addr_d = addr_q + FB_AW'(1);
        end
      end

      ST_DRAIN: state_d = ST_RESP;

      ST_FILL: begin
        if (32'(addr_q) == FB_BYTES - 1) begin
          state_d = ST_RESP;
        end else begin
          addr_d = addr_q + FB_AW'(1);
        end
      end

      ST_READ: state_d = ST_RDATA;

      ST_RDATA: begin
        res_data_d = ram_rdata;
        state_d    = ST_RESP;
      end

      ST_RESP: begin
        if (!m_tvalid_q || m_axis_tready) begin
          m_tvalid_d = 1'b1;
          m_tdata_d  = res_data_q;
          m_tuser_d  = res_valid_q;
          state_d    = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      x_q         <= '0;
      y_q         <= '0;
      w_q         <= '0;
      h_q         <= '0;
      color_q     <= 1'b0;
      solid_q     <= 1'b0;
      ridx_q      <= '0;
      xe_q        <= '0;
      ye_q        <= '0;
      xl_q        <= '0;
      fy_lo_q     <= '0;
      fy_hi_q     <= '0;
      cx_q        <= '0;
      cx_last_q   <= '0;
      cr_q        <= '0;
      cr_first_q  <= '0;
      cr_last_q   <= '0;
      prod_q      <= '0;
      addr_q      <= '0;
      col_base_q  <= '0;
      s1_valid_q  <= 1'b0;
      s1_addr_q   <= '0;
      s1_mask_q   <= '0;
      res_data_q  <= '0;
      res_valid_q <= 1'b0;
      m_tvalid_q  <= 1'b0;
      m_tdata_q   <= '0;
      m_tuser_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      x_q         <= x_d;
      y_q         <= y_d;
      w_q         <= w_d;
      h_q         <= h_d;
      color_q     <= color_d;
      solid_q     <= solid_d;
      ridx_q      <= ridx_d;
      xe_q        <= xe_d;
      ye_q        <= ye_d;
      xl_q        <= xl_d;
      fy_lo_q     <= fy_lo_d;
      fy_hi_q     <= fy_hi_d;
      cx_q        <= cx_d;
      cx_last_q   <= cx_last_d;
      cr_q        <= cr_d;
      cr_first_q  <= cr_first_d;
      cr_last_q   <= cr_last_d;
      prod_q      <= prod_d;
      addr_q      <= addr_d;
      col_base_q  <= col_base_d;
      s1_valid_q  <= s1_valid_d;
      s1_addr_q   <= s1_addr_d;
      s1_mask_q   <= s1_mask_d;
      res_data_q  <= res_data_d;
      res_valid_q <= res_valid_d;
      m_tvalid_q  <= m_tvalid_d;
      m_tdata_q   <= m_tdata_d;
      m_tuser_q   <= m_tuser_d;
    end
  end

  // The read-modify-write overlap relies on the walk never revisiting a byte.
  `ASSERT_DFLT(a_rmw_no_collision, (ram_we && ram_re) |-> (ram_waddr != ram_raddr), "RAM read and write hit the same byte")
  `ASSERT_DFLT(a_accept_leaves_idle, in_accept |=> (state_q != ST_IDLE), "accepted item left sequencer idle")
  `ASSERT_DFLT(a_result_from_resp, $rose(m_tvalid_q) |-> $past(state_q == ST_RESP), "result appeared outside response step")
  `ASSERT_DFLT(a_writeback_after_walk, s1_valid_q |-> $past(state_q == ST_WALK), "write-back without a walk read")

endmodule

`default_nettype wire

// ----- verif/pmrde_frame_checker.sv -----
// ----------------------------------------------------------------------------
// pmrde_frame_checker
// Scoreboard for the packed monochrome draw engine. It keeps its own shadow of
// the framebuffer, predicts the response of every accepted command and checks
// each response transfer against the oldest prediction.
// ----------------------------------------------------------------------------

module pmrde_frame_checker
  import pmrde_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,

  input  logic        s_tvalid_i,
  input  logic        s_tready_i,
  // [8:0] x_pos, [17:9] y_pos, [27:18] rect_width, [37:28] rect_height,
  // [38] color, [39] filled, [53:40] read_index, [55:54] zero
  input  logic [55:0] s_tdata_i,
  // [1:0] operation
  input  logic [1:0]  s_tuser_i,

  input  logic        m_tvalid_i,
  input  logic        m_tready_i,
  // [7:0] read_data
  input  logic [7:0]  m_tdata_i,
  // [0] index_valid
  input  logic [0:0]  m_tuser_i,

  output int          error_count_o,
  output int          pending_o
);

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0] read_data;
    logic       index_valid;
  } draw_resp_t;

  logic [7:0] shadow_frame [FB_BYTES];
  draw_resp_t expected_resp_q [$];

  int errors;
  int cmds_seen;
  int resps_seen;

  assign error_count_o = errors;
  assign pending_o     = cmds_seen - resps_seen;

  // Flipped vertical axis, column-of-cells major byte order.
  task automatic shade_pixel(input int x, input int y, input bit white);
    int fy;
    int idx;
    int bitpos;
    if (x >= SCREEN_WIDTH || y >= SCREEN_HEIGHT) return;
    fy     = SCREEN_HEIGHT - 1 - y;
    idx    = (x / CELL_W) * CELL_ROWS + fy / CELL_H;
    bitpos = 7 - ((fy % CELL_H) * CELL_W + x % CELL_W);
    if (idx >= FB_BYTES) return;
    shadow_frame[idx][bitpos] = white;
  endtask

  task automatic shade_rect(input int x, input int y, input int w, input int h,
                            input bit white, input bit solid);
    int xe;
    int ye;
    if (w == 0 || h == 0) return;
    xe = (x + w > SCREEN_WIDTH)  ? SCREEN_WIDTH  : x + w;
    ye = (y + h > SCREEN_HEIGHT) ? SCREEN_HEIGHT : y + h;
    // The outline follows the edges left after clipping.
    for (int py = y; py < ye; py++) begin
      for (int px = x; px < xe; px++) begin
        if (solid || py == y || py == ye - 1 || px == x || px == xe - 1)
          shade_pixel(px, py, white);
      end
    end
  endtask

  task automatic predict_draw(input op_e op, input logic [55:0] args,
                              output draw_resp_t resp);
    int  ridx;
    bit  white;
    ridx  = args[53:40];
    white = args[38];
    resp  = '{read_data: 8'h00, index_valid: 1'b1};
    case (op)
      OP_PIXEL: shade_pixel(args[8:0], args[17:9], white);
      OP_RECT:  shade_rect(args[8:0], args[17:9], args[27:18], args[37:28],
                           white, args[39]);
      OP_FILL: begin
        foreach (shadow_frame[i]) shadow_frame[i] = white ? BYTE_WHITE : BYTE_BLACK;
      end
      default: begin
        if (ridx < FB_BYTES) resp.read_data = shadow_frame[ridx];
        else resp.index_valid = 1'b0;
      end
    endcase
  endtask

  initial begin
    errors     = 0;
    cmds_seen  = 0;
    resps_seen = 0;
  end

  always @(posedge clk_i) begin
    draw_resp_t want;
    draw_resp_t got;
    if (rst_ni) begin
      if (s_tvalid_i && s_tready_i) begin
        predict_draw(op_e'(s_tuser_i), s_tdata_i, want);
        expected_resp_q.push_back(want);
        cmds_seen <= cmds_seen + 1;
      end
      if (m_tvalid_i && m_tready_i) begin
        got = '{read_data: m_tdata_i, index_valid: m_tuser_i[0]};
        resps_seen <= resps_seen + 1;
        if (expected_resp_q.size() == 0) begin
          if (errors < 10)
            $display("%0t: response with nothing pending: data %h valid %b",
                     $realtime, got.read_data, got.index_valid);
          errors++;
        end else begin
          want = expected_resp_q.pop_front();
          if (got.read_data !== want.read_data || got.index_valid !== want.index_valid) begin
            if (errors < 10)
              $display("%0t: mismatch: expected data %h valid %b, got data %h valid %b",
                       $realtime, want.read_data, want.index_valid,
                       got.read_data, got.index_valid);
            errors++;
          end
        end
      end
    end
  end

endmodule

// ----- verif/packed_mono_rect_draw_engine_test.sv -----
// ----------------------------------------------------------------------------
// packed_mono_rect_draw_engine_test
// Top of the draw engine testbench. It runs a directed pass over fills,
// pixels, clipped and empty rectangles and reads, then a random mix of
// commands, with random gaps on both streams. A separate checker predicts
// and compares every response; this module only drives and gives the verdict.
// ----------------------------------------------------------------------------

module packed_mono_rect_draw_engine_test;

  timeunit 1ns;
  timeprecision 1ps;

  import pmrde_pkg::*;

  // A fill or a full-screen rectangle walks all 15000 bytes, so the watchdog
  // allows several of those walks without any transfer before giving up.
  localparam int IDLE_LIMIT    = 80000;
  localparam int DRAIN_CYCLES  = 40;
  localparam int RANDOM_ITEMS  = 100;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [55:0] s_axis_tdata;
  logic [1:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [7:0]  m_axis_tdata;
  logic [0:0]  m_axis_tuser;

  int error_count;
  int pending;

  // When set, the matching side runs without gaps for a while.
  bit sender_burst;
  bit receiver_burst;

  // Last on-screen point touched by a drawing command, so that random reads
  // can land on bytes that have just been changed.
  int last_x;
  int last_y;

  packed_mono_rect_draw_engine dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  pmrde_frame_checker checker_i (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_tvalid_i    (s_axis_tvalid),
    .s_tready_i    (s_axis_tready),
    .s_tdata_i     (s_axis_tdata),
    .s_tuser_i     (s_axis_tuser),
    .m_tvalid_i    (m_axis_tvalid),
    .m_tready_i    (m_axis_tready),
    .m_tdata_i     (m_axis_tdata),
    .m_tuser_i     (m_axis_tuser),
    .error_count_o (error_count),
    .pending_o     (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Byte index of an on-screen pixel, used only to aim reads.
  function automatic int cell_byte(input int x, input int y);
    return (x / CELL_W) * CELL_ROWS + (SCREEN_HEIGHT - 1 - y) / CELL_H;
  endfunction

  // Sends one command transfer. A gap, when drawn, drops tvalid first; when
  // no gap is drawn the valid stays high straight into the next transfer.
  task automatic send_cmd(input op_e op, input int x, input int y, input int w,
                          input int h, input bit color, input bit filled,
                          input int ridx);
    int gap;
    gap = sender_burst ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tuser  <= op;
    s_axis_tdata  <= {2'b00, ridx[13:0], filled, color, h[9:0], w[9:0],
                      y[8:0], x[8:0]};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!(s_axis_tvalid && s_axis_tready));
    if (op inside {OP_PIXEL, OP_RECT} && x < SCREEN_WIDTH && y < SCREEN_HEIGHT) begin
      last_x = x;
      last_y = y;
    end
    if ($urandom_range(0, 15) == 0) sender_burst = !sender_burst;
  endtask

  // Holds the command stream off until every response has come back.
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  // Random coordinate, mostly on screen, sometimes anywhere in the field.
  function automatic int rand_coord(input int limit);
    return ($urandom_range(0, 4) == 0) ? $urandom_range(0, 511) : $urandom_range(0, limit - 1);
  endfunction

  // Response side: random stalls on tready, with stretches of none.
  initial begin
    int gap;
    m_axis_tready <= 1'b0;
    @(posedge clk_i);
    forever begin
      gap = receiver_burst ? 0 : $urandom_range(0, 7);
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!(m_axis_tvalid && m_axis_tready));
      if ($urandom_range(0, 15) == 0) receiver_burst = !receiver_burst;
    end
  end

  // Watchdog: ends the run when no transfer happens on either stream for
  // too long.
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("DONE: errors detected");
    $finish;
  end

  // Main stimulus.
  initial begin
    int r;
    int x;
    int y;
    int w;
    int h;
    sender_burst   = 1'b0;
    receiver_burst = 1'b0;
    last_x         = 0;
    last_y         = 0;
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= OP_PIXEL;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed pass. The framebuffer is undefined after reset, so the very
    // first command is a fill; every byte is known from then on.
    send_cmd(OP_FILL, 0, 0, 0, 0, 1'b1, 1'b0, 0);
    send_cmd(OP_READ, 0, 0, 0, 0, 1'b0, 1'b0, 0);
    send_cmd(OP_READ, 0, 0, 0, 0, 1'b0, 1'b0, FB_BYTES - 1);
    // Reads just past the buffer and at the top of the index field.
    send_cmd(OP_READ, 0, 0, 0, 0, 1'b0, 1'b0, FB_BYTES);
    send_cmd(OP_READ, 0, 0, 0, 0, 1'b0, 1'b0, 16383);
    send_cmd(OP_FILL, 0, 0, 0, 0, 1'b0, 1'b0, 0);
    // Pixels at both screen corners, then off-screen ones that are ignored.
    send_cmd(OP_PIXEL, 0, 0, 0, 0, 1'b1, 1'b0, 0);
    send_cmd(OP_READ, 0, 0, 0, 0, 1'b0, 1'b0, cell_byte(0, 0));
    send_cmd(OP_PIXEL, SCREEN_WIDTH - 1, SCREEN_HEIGHT - 1, 0, 0, 1'b1, 1'b0, 0);
    send_cmd(OP_READ, 0, 0, 0, 0, 1'b0, 1'b0,
             cell_byte(SCREEN_WIDTH - 1, SCREEN_HEIGHT - 1));
    send_cmd(OP_PIXEL, SCREEN_WIDTH, 5, 0, 0, 1'b1, 1'b0, 0);
    send_cmd(OP_PIXEL, 511, 511, 0, 0, 1'b1, 1'b0, 0);
    send_cmd(OP_PIXEL, 0, 0, 0, 0, 1'b0, 1'b0, 0);
    send_cmd(OP_READ, 0, 0, 0, 0, 1'b0, 1'b0, cell_byte(0, 0));
    // Filled and outlined rectangles, then both kinds of empty rectangle.
    send_cmd(OP_RECT, 10, 10, 5, 7, 1'b1, 1'b1, 0);
    send_cmd(OP_READ, 0, 0, 0, 0, 1'b0, 1'b0, cell_byte(11, 12));
    send_cmd(OP_RECT, 20, 20, 9, 9, 1'b1, 1'b0, 0);
    send_cmd(OP_READ, 0, 0, 0, 0, 1'b0, 1'b0, cell_byte(20, 24));
    send_cmd(OP_RECT, 30, 30, 0, 5, 1'b1, 1'b1, 0);
    send_cmd(OP_RECT, 30, 30, 5, 0, 1'b1, 1'b1, 0);
    // Outline clipped at the right and bottom edges, and a rectangle whose
    // left column lies past the right edge, so that it draws nothing.
    send_cmd(OP_RECT, 390, 290, 512, 512, 1'b1, 1'b0, 0);
    send_cmd(OP_READ, 0, 0, 0, 0, 1'b0, 1'b0, cell_byte(399, 295));
    send_cmd(OP_RECT, 450, 10, 10, 10, 1'b1, 1'b1, 0);
    // Whole-screen solid rectangle, then a black outline over the screen.
    send_cmd(OP_RECT, 0, 0, 512, 512, 1'b1, 1'b1, 0);
    send_cmd(OP_RECT, 0, 0, SCREEN_WIDTH, SCREEN_HEIGHT, 1'b0, 1'b0, 0);
    send_cmd(OP_READ, 0, 0, 0, 0, 1'b0, 1'b0, cell_byte(0, 150));

    // Let the engine drain completely once before the random mix.
    wait_drained();

    // Random mix. Rectangles are mostly small, since the engine walks each
    // touched byte in turn; fills are rare for the same reason.
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == RANDOM_ITEMS / 2) wait_drained();
      r = $urandom_range(0, 99);
      if (r < 4) begin
        send_cmd(OP_FILL, 0, 0, 0, 0, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                 $urandom_range(0, 16383));
      end else if (r < 38) begin
        x = rand_coord(SCREEN_WIDTH);
        y = rand_coord(SCREEN_HEIGHT);
        send_cmd(OP_PIXEL, x, y, $urandom_range(0, 512), $urandom_range(0, 512),
                 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                 $urandom_range(0, 16383));
      end else if (r < 68) begin
        x = rand_coord(SCREEN_WIDTH);
        y = rand_coord(SCREEN_HEIGHT);
        if ($urandom_range(0, 9) == 0) begin
          w = $urandom_range(0, 512);
          h = $urandom_range(0, 512);
        end else begin
          w = $urandom_range(0, 24);
          h = $urandom_range(0, 24);
        end
        send_cmd(OP_RECT, x, y, w, h, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                 $urandom_range(0, 16383));
      end else begin
        // Half of the reads aim at the last drawn spot, the rest anywhere.
        if ($urandom_range(0, 1) == 0)
          r = cell_byte(last_x, last_y);
        else
          r = $urandom_range(0, 16383);
        send_cmd(OP_READ, $urandom_range(0, 511), $urandom_range(0, 511),
                 $urandom_range(0, 512), $urandom_range(0, 512),
                 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), r);
      end
    end

    // Wait for every response, then keep watching for stray transfers.
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
